// ===== rtl/q2e_pkg.sv =====
// ============================================================================
// q2e_pkg - quaternion to Euler core shared definitions
// Request types, pipeline cell payloads, constants and the CORDIC angle table.
// ============================================================================
`default_nettype none

package q2e_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int DIV_STEPS    = 30;
    localparam int SQRT_STEPS   = 31;
    localparam int NUM_LANES    = 3;
    localparam int LANE_YAW     = 0;
    localparam int LANE_PITCH   = 1;
    localparam int LANE_ROLL    = 2;

    localparam int CW     = 36;
    localparam int AW     = 24;
    localparam int DEN_W  = 33;
    localparam int REM_W  = 34;
    localparam int QW     = 31;
    localparam int RAD_W  = 62;
    localparam int SIDX_W = 5;

    localparam logic signed [AW-1:0] HALF_PI_Q20 = 24'sd1647099;
    localparam logic signed [15:0]   HALF_PI_Q12 = 16'sd6434;
    localparam logic signed [CW-1:0] ONE_Q28     = CW'(64'sd1 <<< 28);
    localparam logic [QW-1:0]        ONE_Q30     = 31'h4000_0000;
    localparam logic [RAD_W-1:0]     ONE_Q60     = 62'd1 << 60;

    typedef enum logic [1:0] {
        BR_REGULAR = 2'd0,
        BR_POS     = 2'd1,
        BR_NEG     = 2'd2
    } branch_t;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } quat_t;

    typedef struct packed {
        logic signed [15:0] yaw_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] roll_angle;
        branch_t            branch_code;
    } euler_t;

    typedef struct packed {
        logic signed [CW-1:0] yaw_y;
        logic signed [CW-1:0] yaw_x;
        logic signed [CW-1:0] roll_y;
        logic signed [CW-1:0] roll_x;
        branch_t              branch;
    } side_t;

    typedef struct packed {
        logic [REM_W-1:0]     rem;
        logic [DEN_W-1:0]     den;
        logic [DIV_STEPS-1:0] quo;
        logic                 sat;
        logic                 zero;
        logic                 neg;
    } div_t;

    typedef struct packed {
        logic [RAD_W-1:0]   rad;
        logic [RAD_W-1:0]   res;
        logic signed [31:0] pitch_s;
    } sqrt_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [AW-1:0] ang;
        logic                 zero;
    } lane_t;

    typedef struct packed {
        lane_t [NUM_LANES-1:0] lane;
        branch_t               branch;
    } cordic_t;

    // atan(2^-i), radians * 2^20
    function automatic logic signed [AW-1:0] atan_q20(input logic [SIDX_W-1:0] idx);
        logic signed [AW-1:0] v;
        unique case (idx)
            5'd0:    v = 24'sd823550;
            5'd1:    v = 24'sd486170;
            5'd2:    v = 24'sd256879;
            5'd3:    v = 24'sd130396;
            5'd4:    v = 24'sd65451;
            5'd5:    v = 24'sd32757;
            5'd6:    v = 24'sd16383;
            5'd7:    v = 24'sd8192;
            5'd8:    v = 24'sd4096;
            5'd9:    v = 24'sd2048;
            5'd10:   v = 24'sd1024;
            5'd11:   v = 24'sd512;
            5'd12:   v = 24'sd256;
            5'd13:   v = 24'sd128;
            5'd14:   v = 24'sd64;
            5'd15:   v = 24'sd32;
            5'd16:   v = 24'sd16;
            5'd17:   v = 24'sd8;
            5'd18:   v = 24'sd4;
            5'd19:   v = 24'sd2;
            5'd20:   v = 24'sd1;
            default: v = 24'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/q2e_div_cell.sv =====
// ============================================================================
// q2e_div_cell - one restoring division step
// Shifts the partial remainder, subtracts the divisor when it fits and
// appends one quotient bit; side data rides along.
// ============================================================================
`default_nettype none

module q2e_div_cell (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire q2e_pkg::div_t  in_div,
    input  wire q2e_pkg::side_t in_side,
    output logic                out_valid,
    output q2e_pkg::div_t       out_div,
    output q2e_pkg::side_t      out_side
);
    import q2e_pkg::*;

    logic             valid_reg;
    div_t             div_reg;
    div_t             div_next;
    side_t            side_reg;
    logic [REM_W:0]   shl;
    logic [REM_W:0]   den_ext;
    logic [REM_W:0]   diff;
    logic             fits;

    assign shl     = {in_div.rem, 1'b0};
    assign den_ext = {{(REM_W + 1 - DEN_W){1'b0}}, in_div.den};
    assign diff    = shl - den_ext;
    assign fits    = (shl >= den_ext);

    always_comb begin
        div_next     = in_div;
        div_next.rem = fits ? diff[REM_W-1:0] : shl[REM_W-1:0];
        div_next.quo = {in_div.quo[DIV_STEPS-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            div_reg  <= div_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_div   = div_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

// ===== rtl/q2e_sqrt_cell.sv =====
// ============================================================================
// q2e_sqrt_cell - one digit of the integer square root
// Tests one result bit per cycle while en is high, bit weight set by the step index.
// ============================================================================
`default_nettype none

module q2e_sqrt_cell (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic [q2e_pkg::SIDX_W-1:0]    step_idx,
    input  wire logic                          in_valid,
    input  wire q2e_pkg::sqrt_t                in_sq,
    input  wire q2e_pkg::side_t                in_side,
    output logic                               out_valid,
    output q2e_pkg::sqrt_t                     out_sq,
    output q2e_pkg::side_t                     out_side
);
    import q2e_pkg::*;

    logic             valid_reg;
    sqrt_t            sq_reg;
    sqrt_t            sq_next;
    side_t            side_reg;
    logic [5:0]       sh;
    logic [RAD_W-1:0] bitv;
    logic [RAD_W-1:0] trial;
    logic             fits;

    assign sh    = 6'(2 * (SQRT_STEPS - 1)) - {step_idx, 1'b0};
    assign bitv  = {{(RAD_W - 1){1'b0}}, 1'b1} << sh;
    assign trial = in_sq.res + bitv;
    assign fits  = (in_sq.rad >= trial);

    always_comb begin
        sq_next     = in_sq;
        sq_next.rad = fits ? (in_sq.rad - trial) : in_sq.rad;
        sq_next.res = fits ? ((in_sq.res >> 1) + bitv) : (in_sq.res >> 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg   <= sq_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_sq    = sq_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

// ===== rtl/q2e_cordic_cell.sv =====
// ============================================================================
// q2e_cordic_cell - one vectoring CORDIC iteration
// Rotates the yaw, pitch and roll vectors toward the x axis by atan(2^-i).
// ============================================================================
`default_nettype none

module q2e_cordic_cell (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic [q2e_pkg::SIDX_W-1:0]    step_idx,
    input  wire logic                          in_valid,
    input  wire q2e_pkg::cordic_t              in_data,
    output logic                               out_valid,
    output q2e_pkg::cordic_t                   out_data
);
    import q2e_pkg::*;

    logic    valid_reg;
    cordic_t data_reg;
    cordic_t data_next;

    function automatic lane_t rotate(input lane_t l, input logic [SIDX_W-1:0] idx);
        lane_t                r;
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        logic signed [AW-1:0] da;
        xs = l.x >>> idx;
        ys = l.y >>> idx;
        da = atan_q20(idx);
        r  = l;
        if (l.y > 0) begin
            r.x   = l.x + ys;
            r.y   = l.y - xs;
            r.ang = l.ang + da;
        end else begin
            r.x   = l.x - ys;
            r.y   = l.y + xs;
            r.ang = l.ang - da;
        end
        return r;
    endfunction

    always_comb begin
        data_next = in_data;
        for (int k = 0; k < NUM_LANES; k++) begin
            data_next.lane[k] = rotate(in_data.lane[k], step_idx);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== rtl/quaternion_to_euler_core.sv =====
// ============================================================================
// quaternion_to_euler_core - quaternion to yaw/pitch/roll
// Products, gimbal-lock test, divider, square root and CORDIC chains.
// ============================================================================
//  channel  | direction | payload                         | handshake
//  s_       | in        | quat_t  (w, x, y, z  Q2.14)     | s_valid / s_ready
//  m_       | out       | euler_t (yaw, pitch, roll Q4.12)| m_valid / m_ready
//
//  One request per cycle while the output is not stalled; 30 divider cells, 31
//  square root cells and 16 CORDIC cells set the depth.
//  Reset clears only the valid bits.
//  A stalled output freezes the whole chain; the input stage still takes a
//  request while it is empty.
// ============================================================================
`default_nettype none

module quaternion_to_euler_core (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire q2e_pkg::quat_t s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output q2e_pkg::euler_t     m_data
);
    import q2e_pkg::*;

    logic en;
    logic a_load;

    // input
    logic  a_valid_reg;
    quat_t a_q_reg;

    // products
    logic               b_valid_reg;
    logic signed [31:0] b_w2_reg, b_x2_reg, b_y2_reg, b_z2_reg;
    logic signed [31:0] b_wx_reg, b_yz_reg, b_wz_reg, b_xy_reg, b_wy_reg, b_xz_reg;
    logic signed [15:0] b_w_reg, b_y_reg;

    // sums
    logic               c_valid_reg;
    logic [DEN_W-1:0]   c_n_reg;
    logic signed [32:0] c_p_reg;
    side_t              c_side_reg;
    side_t              c_side_next;
    logic signed [15:0] c_w_reg, c_y_reg;

    // branch test and divider setup
    logic               d_valid_reg;
    div_t               d_div_reg;
    div_t               d_div_next;
    side_t              d_side_reg;
    side_t              d_side_next;
    logic signed [59:0] lhs, rhs;
    logic signed [33:0] num;
    logic [REM_W-1:0]   mag;
    branch_t            br;

    logic  div_v [0:DIV_STEPS];
    div_t  div_d [0:DIV_STEPS];
    side_t div_s [0:DIV_STEPS];

    // quotient finish
    logic               e_valid_reg;
    logic [QW-1:0]      e_q_reg;
    logic [QW-1:0]      e_q_next;
    logic signed [31:0] e_s_reg;
    side_t              e_side_reg;

    // square
    logic               f_valid_reg;
    logic [RAD_W-1:0]   f_sq_reg;
    logic signed [31:0] f_s_reg;
    side_t              f_side_reg;

    // radicand
    logic             g_valid_reg;
    sqrt_t            g_sq_reg;
    side_t            g_side_reg;

    logic  sq_v [0:SQRT_STEPS];
    sqrt_t sq_d [0:SQRT_STEPS];
    side_t sq_s [0:SQRT_STEPS];

    // pre-rotation
    logic    p_valid_reg;
    cordic_t p_data_reg;
    cordic_t p_data_next;

    logic    cr_v [0:CORDIC_STEPS];
    cordic_t cr_d [0:CORDIC_STEPS];

    // output
    logic   o_valid_reg;
    euler_t o_data_reg;
    euler_t o_data_next;

    function automatic lane_t prerot(input logic signed [CW-1:0] py,
                                     input logic signed [CW-1:0] px);
        lane_t l;
        l.zero = (px == '0) && (py == '0);
        l.x    = px;
        l.y    = py;
        l.ang  = '0;
        if (px < 0) begin
            if (py >= 0) begin
                l.x   = py;
                l.y   = -px;
                l.ang = HALF_PI_Q20;
            end else begin
                l.x   = -py;
                l.y   = px;
                l.ang = -HALF_PI_Q20;
            end
        end
        return l;
    endfunction

    function automatic logic signed [15:0] to_q12(input logic signed [AW:0] a);
        logic signed [AW:0] t;
        logic signed [AW:0] r;
        logic signed [15:0] o;
        t = a + (AW + 1)'(128);
        r = t >>> 8;
        if (r > (AW + 1)'(32767)) begin
            o = 16'sh7FFF;
        end else if (r < -(AW + 1)'(32768)) begin
            o = -16'sh8000;
        end else begin
            o = r[15:0];
        end
        return o;
    endfunction

    function automatic logic signed [AW:0] lane_ang(input lane_t l);
        return l.zero ? '0 : (AW + 1)'(l.ang);
    endfunction

    assign en      = !o_valid_reg || m_ready;
    assign a_load  = en || !a_valid_reg;
    assign s_ready = a_load;

    // ---------------- input stage ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_load) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_load) begin
            a_q_reg <= s_data;
        end
    end

    // ---------------- products ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_w2_reg <= a_q_reg.quat_w * a_q_reg.quat_w;
            b_x2_reg <= a_q_reg.quat_x * a_q_reg.quat_x;
            b_y2_reg <= a_q_reg.quat_y * a_q_reg.quat_y;
            b_z2_reg <= a_q_reg.quat_z * a_q_reg.quat_z;
            b_wx_reg <= a_q_reg.quat_w * a_q_reg.quat_x;
            b_yz_reg <= a_q_reg.quat_y * a_q_reg.quat_z;
            b_wz_reg <= a_q_reg.quat_w * a_q_reg.quat_z;
            b_xy_reg <= a_q_reg.quat_x * a_q_reg.quat_y;
            b_wy_reg <= a_q_reg.quat_w * a_q_reg.quat_y;
            b_xz_reg <= a_q_reg.quat_x * a_q_reg.quat_z;
            b_w_reg  <= a_q_reg.quat_w;
            b_y_reg  <= a_q_reg.quat_y;
        end
    end

    // ---------------- sums ----------------
    always_comb begin
        c_side_next.yaw_y  = (CW'(b_wz_reg) - CW'(b_xy_reg)) <<< 1;
        c_side_next.yaw_x  = ONE_Q28 - ((CW'(b_z2_reg) + CW'(b_x2_reg)) <<< 1);
        c_side_next.roll_y = (CW'(b_wy_reg) - CW'(b_xz_reg)) <<< 1;
        c_side_next.roll_x = ONE_Q28 - ((CW'(b_y2_reg) + CW'(b_x2_reg)) <<< 1);
        c_side_next.branch = BR_REGULAR;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_n_reg    <= DEN_W'($unsigned(b_w2_reg)) + DEN_W'($unsigned(b_x2_reg))
                        + DEN_W'($unsigned(b_y2_reg)) + DEN_W'($unsigned(b_z2_reg));
            c_p_reg    <= 33'(b_wx_reg) + 33'(b_yz_reg);
            c_side_reg <= c_side_next;
            c_w_reg    <= b_w_reg;
            c_y_reg    <= b_y_reg;
        end
    end

    // ---------------- branch test, divider setup ----------------
    // (0.5 - eps) * n * 2^24 = n * 2^23 - n * 2
    always_comb begin
        lhs = 60'(c_p_reg) <<< 24;
        rhs = (60'($signed({1'b0, c_n_reg})) <<< 23) - (60'($signed({1'b0, c_n_reg})) <<< 1);
        num = 34'(c_p_reg) <<< 1;
        mag = (num < 0) ? $unsigned(-num) : $unsigned(num);
        priority if (lhs > rhs) begin
            br = BR_POS;
        end else if (lhs < -rhs) begin
            br = BR_NEG;
        end else begin
            br = BR_REGULAR;
        end

        d_div_next.rem  = mag;
        d_div_next.den  = c_n_reg;
        d_div_next.quo  = '0;
        d_div_next.sat  = (mag >= {1'b0, c_n_reg});
        d_div_next.zero = (c_n_reg == '0);
        d_div_next.neg  = (num < 0);

        d_side_next        = c_side_reg;
        d_side_next.branch = br;
        if (br != BR_REGULAR) begin
            d_side_next.yaw_y = CW'(c_y_reg);
            d_side_next.yaw_x = CW'(c_w_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_div_reg  <= d_div_next;
            d_side_reg <= d_side_next;
        end
    end

    // ---------------- divider chain ----------------
    assign div_v[0] = d_valid_reg;
    assign div_d[0] = d_div_reg;
    assign div_s[0] = d_side_reg;

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        q2e_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (div_v[k]),
            .in_div    (div_d[k]),
            .in_side   (div_s[k]),
            .out_valid (div_v[k+1]),
            .out_div   (div_d[k+1]),
            .out_side  (div_s[k+1])
        );
    end

    // ---------------- quotient finish, square, radicand ----------------
    always_comb begin
        priority if (div_d[DIV_STEPS].zero) begin
            e_q_next = '0;
        end else if (div_d[DIV_STEPS].sat) begin
            e_q_next = ONE_Q30;
        end else begin
            e_q_next = {1'b0, div_d[DIV_STEPS].quo};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
        end else if (en) begin
            e_valid_reg <= div_v[DIV_STEPS];
            f_valid_reg <= e_valid_reg;
            g_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_q_reg          <= e_q_next;
            e_s_reg          <= div_d[DIV_STEPS].neg ? -$signed({1'b0, e_q_next})
                                                     : $signed({1'b0, e_q_next});
            e_side_reg       <= div_s[DIV_STEPS];
            f_sq_reg         <= RAD_W'(e_q_reg) * RAD_W'(e_q_reg);
            f_s_reg          <= e_s_reg;
            f_side_reg       <= e_side_reg;
            g_sq_reg.rad     <= ONE_Q60 - f_sq_reg;
            g_sq_reg.res     <= '0;
            g_sq_reg.pitch_s <= f_s_reg;
            g_side_reg       <= f_side_reg;
        end
    end

    // ---------------- square root chain ----------------
    assign sq_v[0] = g_valid_reg;
    assign sq_d[0] = g_sq_reg;
    assign sq_s[0] = g_side_reg;

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        q2e_sqrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .step_idx  (SIDX_W'(k)),
            .in_valid  (sq_v[k]),
            .in_sq     (sq_d[k]),
            .in_side   (sq_s[k]),
            .out_valid (sq_v[k+1]),
            .out_sq    (sq_d[k+1]),
            .out_side  (sq_s[k+1])
        );
    end

    // ---------------- pre-rotation ----------------
    always_comb begin
        p_data_next.lane[LANE_YAW]   = prerot(sq_s[SQRT_STEPS].yaw_y, sq_s[SQRT_STEPS].yaw_x);
        p_data_next.lane[LANE_PITCH] = prerot(CW'(sq_d[SQRT_STEPS].pitch_s),
                                              CW'($signed({1'b0, sq_d[SQRT_STEPS].res[QW-1:0]})));
        p_data_next.lane[LANE_ROLL]  = prerot(sq_s[SQRT_STEPS].roll_y, sq_s[SQRT_STEPS].roll_x);
        p_data_next.branch           = sq_s[SQRT_STEPS].branch;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (en) begin
            p_valid_reg <= sq_v[SQRT_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_data_reg <= p_data_next;
        end
    end

    // ---------------- CORDIC chain ----------------
    assign cr_v[0] = p_valid_reg;
    assign cr_d[0] = p_data_reg;

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
        q2e_cordic_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .step_idx  (SIDX_W'(k)),
            .in_valid  (cr_v[k]),
            .in_data   (cr_d[k]),
            .out_valid (cr_v[k+1]),
            .out_data  (cr_d[k+1])
        );
    end

    // ---------------- output ----------------
    always_comb begin
        logic signed [AW:0] ya;
        ya = lane_ang(cr_d[CORDIC_STEPS].lane[LANE_YAW]);
        o_data_next.branch_code = cr_d[CORDIC_STEPS].branch;
        unique case (cr_d[CORDIC_STEPS].branch)
            BR_POS: begin
                o_data_next.yaw_angle   = to_q12(ya <<< 1);
                o_data_next.pitch_angle = HALF_PI_Q12;
                o_data_next.roll_angle  = '0;
            end
            BR_NEG: begin
                o_data_next.yaw_angle   = to_q12(-(ya <<< 1));
                o_data_next.pitch_angle = -HALF_PI_Q12;
                o_data_next.roll_angle  = '0;
            end
            default: begin
                o_data_next.yaw_angle   = to_q12(ya);
                o_data_next.pitch_angle = to_q12(lane_ang(cr_d[CORDIC_STEPS].lane[LANE_PITCH]));
                o_data_next.roll_angle  = to_q12(lane_ang(cr_d[CORDIC_STEPS].lane[LANE_ROLL]));
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (en) begin
            o_valid_reg <= cr_v[CORDIC_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            o_data_reg <= o_data_next;
        end
    end

    assign m_valid = o_valid_reg;
    assign m_data  = o_data_reg;

    // ---------------- assertions ----------------
    ap_zero_norm_regular: assert property (@(posedge aclk) disable iff (!aresetn)
        d_valid_reg && d_div_reg.zero |-> d_side_reg.branch == BR_REGULAR)
        else $error("zero norm took a singular branch");

    ap_quot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        e_valid_reg |-> e_q_reg <= ONE_Q30)
        else $error("quotient above one");

    ap_radicand_range: assert property (@(posedge aclk) disable iff (!aresetn)
        g_valid_reg |-> g_sq_reg.rad <= ONE_Q60)
        else $error("radicand out of range");

    ap_singular_roll: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.branch_code != BR_REGULAR |-> m_data.roll_angle == 16'sd0)
        else $error("singular request with nonzero roll");

    ap_input_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && !en |=> a_valid_reg)
        else $error("input stage dropped a request during stall");

endmodule

`default_nettype wire

// ===== tb/sv/tb_quaternion_to_euler_core.sv =====
// ----------------------------------------------------------------------------
// tb_quaternion_to_euler_core
// Drives quaternion requests with random gaps and output back-pressure, and
// checks every Euler result against a fixed-point predictor in the scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_quaternion_to_euler_core;
    import q2e_pkg::*;

    localparam int ANGLE_STEPS = 16;
    localparam int WATCHDOG_CYCLES = 20000;
    localparam int DRAIN_CYCLES = 200;
    localparam int RANDOM_REQUESTS = 750;

    class euler_scoreboard;
        euler_t pending[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        static function longint floor_shift(longint v, int s);
            return v >>> s;
        endfunction

        static function longint atan_step(int i);
            longint t[24] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                              4096, 2048, 1024, 512, 256, 128, 64, 32,
                              16, 8, 4, 2, 1, 0, 0, 0};
            return t[i];
        endfunction

        static function longint vector_angle(longint y, longint x);
            longint ang, t, xs, ys;
            ang = 0;
            if (x == 0 && y == 0) return 0;
            if (x < 0) begin
                if (y >= 0) begin
                    t = x; x = y; y = -t; ang = 1647099;
                end else begin
                    t = x; x = -y; y = t; ang = -1647099;
                end
            end
            for (int i = 0; i < ANGLE_STEPS && i < 24; i++) begin
                xs = floor_shift(x, i);
                ys = floor_shift(y, i);
                if (y > 0) begin
                    x = x + ys; y = y - xs; ang += atan_step(i);
                end else begin
                    x = x - ys; y = y + xs; ang -= atan_step(i);
                end
            end
            return ang;
        endfunction

        static function logic [63:0] int_sqrt(logic [63:0] v);
            logic [63:0] r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        static function logic signed [15:0] to_angle(longint a);
            longint r;
            r = floor_shift(a + 128, 8);
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            return 16'(r);
        endfunction

        static function euler_t convert(quat_t q);
            euler_t e;
            longint w, x, y, z, w2, x2, y2, z2, n, p, num, s, c;
            logic [63:0] mag, quo;
            w = q.quat_w; x = q.quat_x; y = q.quat_y; z = q.quat_z;
            w2 = w * w; x2 = x * x; y2 = y * y; z2 = z * z;
            n = w2 + x2 + y2 + z2;
            p = w * x + y * z;
            if (p * (64'sd1 << 24) > 64'sd8388606 * n) begin
                e.yaw_angle = to_angle(2 * vector_angle(y, w));
                e.pitch_angle = HALF_PI_Q12;
                e.roll_angle = 0;
                e.branch_code = BR_POS;
            end else if (p * (64'sd1 << 24) < -64'sd8388606 * n) begin
                e.yaw_angle = to_angle(-2 * vector_angle(y, w));
                e.pitch_angle = -HALF_PI_Q12;
                e.roll_angle = 0;
                e.branch_code = BR_NEG;
            end else begin
                num = 2 * p;
                mag = num < 0 ? -num : num;
                quo = 0;
                if (n > 0) quo = (mag << 30) / n;
                if (quo > (64'd1 << 30)) quo = 64'd1 << 30;
                s = num < 0 ? -longint'(quo) : longint'(quo);
                c = int_sqrt((64'sd1 << 60) - s * s);
                e.yaw_angle = to_angle(vector_angle(2 * (w * z - x * y),
                                                    (64'sd1 << 28) - 2 * (z2 + x2)));
                e.pitch_angle = to_angle(vector_angle(s, c));
                e.roll_angle = to_angle(vector_angle(2 * (w * y - x * z),
                                                     (64'sd1 << 28) - 2 * (y2 + x2)));
                e.branch_code = BR_REGULAR;
            end
            return e;
        endfunction

        function void note_request(quat_t q);
            pending.push_back(convert(q));
        endfunction

        function void check_result(euler_t got);
            euler_t exp_e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp_e = pending.pop_front();
            if (got.yaw_angle !== exp_e.yaw_angle)
                $display("%0t: yaw expected %0d actual %0d", $time,
                         exp_e.yaw_angle, got.yaw_angle);
            if (got.pitch_angle !== exp_e.pitch_angle)
                $display("%0t: pitch expected %0d actual %0d", $time,
                         exp_e.pitch_angle, got.pitch_angle);
            if (got.roll_angle !== exp_e.roll_angle)
                $display("%0t: roll expected %0d actual %0d", $time,
                         exp_e.roll_angle, got.roll_angle);
            if (got.branch_code !== exp_e.branch_code)
                $display("%0t: branch expected %0d actual %0d", $time,
                         exp_e.branch_code, got.branch_code);
            if (got !== exp_e) errors++;
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    quat_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    euler_t m_data;

    euler_scoreboard board = new();
    bit sending_done = 1'b0;
    int idle_cycles = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    quaternion_to_euler_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [15:0] pick_part();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sd0;
            3: return 16'sh4000;
            4: return 16'shc000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic quat_t pick_request();
        quat_t q;
        int r;
        logic signed [15:0] a;
        r = $urandom_range(0, 9);
        q.quat_w = pick_part(); q.quat_x = pick_part();
        q.quat_y = pick_part(); q.quat_z = pick_part();
        if (r < 2) begin
            // near gimbal lock: w = +-x, y = +-z
            a = 16'($urandom_range(0, 1) ? q.quat_w : -q.quat_w);
            q.quat_x = a;
            q.quat_z = 16'($urandom_range(0, 1) ? q.quat_y : -q.quat_y);
            if ((a >= 0) != (q.quat_w >= 0) || a == 0) q.quat_z = -q.quat_y;
            if (q.quat_w == a && q.quat_w != 0) q.quat_z = q.quat_y;
            if ($urandom_range(0, 2) == 0) q.quat_z = q.quat_z + $signed(3'($urandom) - 3'sd4);
        end else if (r < 6) begin
            q.quat_w = 16'($signed($urandom_range(0, 32767)) - 16384);
            q.quat_x = 16'($signed($urandom_range(0, 32767)) - 16384);
            q.quat_y = 16'($signed($urandom_range(0, 32767)) - 16384);
            q.quat_z = 16'($signed($urandom_range(0, 32767)) - 16384);
        end
        return q;
    endfunction

    task automatic send_request(quat_t q);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data <= q;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        board.note_request(q);
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_result(m_data);
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin : receiver
        int gap;
        repeat (6) @(negedge aclk);
        @(negedge aclk);
        m_ready <= 1'b1;
        repeat (200) @(negedge aclk);
        // long hold-off so the pipeline fills and stalls the input
        m_ready <= 1'b0;
        repeat (400) @(negedge aclk);
        forever begin
            m_ready <= 1'b1;
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
            repeat (gap) @(negedge aclk);
            gap = pick_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
    end

    initial begin : sender
        quat_t q;
        logic signed [15:0] edges[6] = '{16'sh7fff, 16'sh8000, 16'sd0, 16'sd1, -16'sd1,
                                          16'sh4000};
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        send_request('0);
        for (int i = 0; i < 6; i++) send_request('{edges[i], edges[(i + 1) % 6],
                                                   edges[(i + 2) % 6], edges[(i + 3) % 6]});
        send_request('{16'sh4000, 16'sh4000, 16'sh4000, 16'sh4000});
        send_request('{16'sh4000, -16'sh4000, 16'sh4000, -16'sh4000});
        send_request('{16'sh2d41, 16'sh2d41, 16'sd0, 16'sd0});
        send_request('{16'sh2d41, -16'sh2d41, 16'sd0, 16'sd0});
        send_request('{16'sd0, 16'sd0, 16'sh4000, 16'sd0});
        send_request('{-16'sh4000, 16'sd0, 16'sd0, 16'sd0});
        send_request('{16'sd0, 16'sh4000, 16'sd0, 16'sd0});
        send_request('{16'sd0, 16'sd0, 16'sd0, 16'sh4000});
        send_request('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
        send_request('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
        send_request('{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff});
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            q = pick_request();
            send_request(q);
        end
        s_valid <= 1'b0;
        sending_done = 1'b1;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/q2e_pkg.sv
rtl/q2e_div_cell.sv
rtl/q2e_sqrt_cell.sv
rtl/q2e_cordic_cell.sv
rtl/quaternion_to_euler_core.sv
tb/sv/tb_quaternion_to_euler_core.sv
